// ===== design/sct_pkg.sv =====
`timescale 1ns / 1ps

package sct_pkg;

  localparam int CHAR_BITS_DEF = 8;
  localparam int LINE_BITS_DEF = 16;
  localparam int POS_BITS_DEF  = 24;

  // result queue: room for the most results one character can cause, plus one
  localparam int MAX_RES = 3;
  localparam int QDEPTH  = 4;

  typedef enum logic [1:0] {
    KIND_OP   = 2'd0,
    KIND_WORD = 2'd1,
    KIND_STR  = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;

endpackage

// ===== design/script_char_tokenizer.sv =====
`timescale 1ns / 1ps

// Script tokenizer: takes one script character per request and returns one result per
// token character, one character late so that the last mark of a token is known. A
// character is taken every cycle while the results keep up, and its results reach the
// output through the input register and then the result queue. The output port
// delivers one result per cycle while out_ready is high, so each result beyond one per
// character (a token end together with an operator, or the final character of the script)
// holds the input back, the four-entry result queue absorbing a short burst. After a
// character marked end_of_data the next character starts a new script at line 0,
// position 0.
module script_char_tokenizer #(
  parameter int CHAR_BITS = sct_pkg::CHAR_BITS_DEF,
  parameter int LINE_BITS = sct_pkg::LINE_BITS_DEF,
  parameter int POS_BITS  = sct_pkg::POS_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CHAR_BITS-1:0] in_ch,
  input  logic                 in_end_of_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CHAR_BITS-1:0] out_tok_char,
  output logic [1:0]           out_kind,
  output logic                 out_token_first,
  output logic                 out_token_last,
  output logic                 out_empty_string,
  output logic [LINE_BITS-1:0] out_line,
  output logic [POS_BITS-1:0]  out_offset,
  output logic                 out_run_last
);

  localparam int CNT_BITS = $clog2(sct_pkg::QDEPTH + 1);
  localparam int RN_BITS  = $clog2(sct_pkg::MAX_RES + 1);
  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
  localparam logic [POS_BITS-1:0]  POS_MAX  = {POS_BITS{1'b1}};

  typedef struct packed {
    logic [CHAR_BITS-1:0] tok_char;
    sct_pkg::kind_t       kind;
    logic                 token_first;
    logic                 token_last;
    logic                 empty_string;
    logic [LINE_BITS-1:0] line;
    logic [POS_BITS-1:0]  offset;
    logic                 run_last;
  } res_t;

  function automatic logic [CHAR_BITS-1:0] cx(input logic [7:0] code);
    cx = CHAR_BITS'(code);
  endfunction

  function automatic logic is_space(input logic [CHAR_BITS-1:0] c);
    is_space = (c == cx(sct_pkg::CH_SPACE)) || (c == cx(sct_pkg::CH_TAB)) ||
               (c == cx(sct_pkg::CH_CR)) || (c == cx(sct_pkg::CH_LF)) ||
               (c == cx(sct_pkg::CH_NUL));
  endfunction

  function automatic logic is_op(input logic [CHAR_BITS-1:0] c);
    is_op = (c == cx(sct_pkg::CH_COMMA)) || (c == cx(sct_pkg::CH_EQ)) ||
            (c == cx(sct_pkg::CH_LPAR)) || (c == cx(sct_pkg::CH_RPAR)) ||
            (c == cx(sct_pkg::CH_SEMI)) || (c == cx(sct_pkg::CH_LBRACE)) ||
            (c == cx(sct_pkg::CH_RBRACE)) || (c == cx(sct_pkg::CH_LT)) ||
            (c == cx(sct_pkg::CH_PLUS)) || (c == cx(sct_pkg::CH_MINUS)) ||
            (c == cx(sct_pkg::CH_STAR)) || (c == cx(sct_pkg::CH_SLASH)) ||
            (c == cx(sct_pkg::CH_GT));
  endfunction

  function automatic res_t mk_res(input logic [CHAR_BITS-1:0] c, input sct_pkg::kind_t k,
                                  input logic f, input logic l, input logic e,
                                  input logic [LINE_BITS-1:0] ln,
                                  input logic [POS_BITS-1:0] off);
    res_t r;
    r.tok_char     = c;
    r.kind         = k;
    r.token_first  = f;
    r.token_last   = l;
    r.empty_string = e;
    r.line         = ln;
    r.offset       = off;
    r.run_last     = 1'b0;
    mk_res = r;
  endfunction

  // input register
  logic                 ivalid_r;
  logic                 ivalid_nxt;
  logic [CHAR_BITS-1:0] ich_r;
  logic                 ieod_r;

  // tokenizer state
  logic                 in_comment_r, in_comment_nxt;
  logic                 in_string_r, in_string_nxt;
  logic                 quote_pending_r, quote_pending_nxt;
  logic                 slash_pending_r, slash_pending_nxt;
  logic                 in_word_r, in_word_nxt;
  logic                 held_valid_r, held_valid_nxt;
  logic [CHAR_BITS-1:0] held_char_r, held_char_nxt;
  sct_pkg::kind_t       held_kind_r, held_kind_nxt;
  logic                 held_first_r, held_first_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;
  logic [POS_BITS-1:0]  pos_r, pos_nxt;
  logic [POS_BITS-1:0]  tstart_r, tstart_nxt;
  logic                 halted_r, halted_nxt;

  logic [LINE_BITS-1:0] line_cur;
  logic [POS_BITS-1:0]  pos_cur;
  res_t                 res [sct_pkg::MAX_RES];
  logic [RN_BITS-1:0]   res_n;

  // result queue, head at entry 0
  res_t                 q_r [sct_pkg::QDEPTH];
  res_t                 q_nxt [sct_pkg::QDEPTH];
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic [CNT_BITS-1:0]  cnt_after_pop;
  logic                 pop;
  logic                 proc;

  assign out_valid     = (cnt_r != '0);
  assign pop           = out_valid && out_ready;
  assign cnt_after_pop = cnt_r - CNT_BITS'(pop);
  assign proc          = ivalid_r &&
                         (cnt_after_pop <= CNT_BITS'(sct_pkg::QDEPTH - sct_pkg::MAX_RES));
  assign in_ready      = !ivalid_r || proc;
  assign ivalid_nxt    = in_valid || (ivalid_r && !proc);

  always_comb begin
    logic do_take;
    logic f;
    logic had;
    logic [CHAR_BITS-1:0] c;

    c = ich_r;
    // a finished script restarts from the reset state
    in_comment_nxt    = in_comment_r && !halted_r;
    in_string_nxt     = in_string_r && !halted_r;
    quote_pending_nxt = quote_pending_r && !halted_r;
    slash_pending_nxt = slash_pending_r && !halted_r;
    in_word_nxt       = in_word_r && !halted_r;
    held_valid_nxt    = held_valid_r && !halted_r;
    held_char_nxt     = halted_r ? '0 : held_char_r;
    held_kind_nxt     = halted_r ? sct_pkg::KIND_OP : held_kind_r;
    held_first_nxt    = held_first_r && !halted_r;
    line_nxt          = halted_r ? '0 : line_r;
    pos_nxt           = halted_r ? '0 : pos_r;
    tstart_nxt        = halted_r ? '0 : tstart_r;
    halted_nxt        = 1'b0;
    line_cur          = line_nxt;
    pos_cur           = pos_nxt;
    res_n             = '0;
    for (int k = 0; k < sct_pkg::MAX_RES; k++) begin
      res[k] = '0;
    end
    do_take = 1'b1;
    f       = 1'b0;
    had     = 1'b0;

    // one-character lookahead left by the previous character
    if (slash_pending_nxt) begin
      slash_pending_nxt = 1'b0;
      if (c == cx(sct_pkg::CH_SLASH)) begin
        in_comment_nxt = 1'b1;
        do_take        = 1'b0;
      end else begin
        if (held_valid_nxt) begin
          res[res_n[1:0]] = mk_res(held_char_nxt, held_kind_nxt, held_first_nxt, 1'b0,
                                   1'b0, line_cur, tstart_nxt);
          res_n = res_n + 1'b1;
        end
        held_valid_nxt = 1'b1;
        held_char_nxt  = cx(sct_pkg::CH_SLASH);
        held_kind_nxt  = sct_pkg::KIND_OP;
        held_first_nxt = 1'b1;
      end
    end else if (quote_pending_nxt) begin
      quote_pending_nxt = 1'b0;
      if (c == cx(sct_pkg::CH_DQUOTE)) begin
        do_take = 1'b0;
        f       = !held_valid_nxt;
        if (held_valid_nxt) begin
          res[res_n[1:0]] = mk_res(held_char_nxt, held_kind_nxt, held_first_nxt, 1'b0,
                                   1'b0, line_cur, tstart_nxt);
          res_n = res_n + 1'b1;
        end
        held_valid_nxt = 1'b1;
        held_char_nxt  = cx(sct_pkg::CH_DQUOTE);
        held_kind_nxt  = sct_pkg::KIND_STR;
        held_first_nxt = f;
      end else begin
        // closing quote
        if (held_valid_nxt) begin
          res[res_n[1:0]] = mk_res(held_char_nxt, held_kind_nxt, held_first_nxt, 1'b1,
                                   1'b0, line_cur, pos_cur);
          held_valid_nxt = 1'b0;
        end else begin
          res[res_n[1:0]] = mk_res('0, sct_pkg::KIND_STR, 1'b1, 1'b1, 1'b1, line_cur,
                                   pos_cur);
        end
        res_n = res_n + 1'b1;
        in_string_nxt = 1'b0;
      end
    end

    if (do_take) begin
      if (in_comment_nxt) begin
        if (c == cx(sct_pkg::CH_LF)) begin
          in_comment_nxt = 1'b0;
          if (line_nxt != LINE_MAX) line_nxt = line_nxt + 1'b1;
        end
      end else if (in_string_nxt) begin
        if (c == cx(sct_pkg::CH_DQUOTE)) begin
          quote_pending_nxt = 1'b1;
        end else begin
          f = !held_valid_nxt;
          if (held_valid_nxt) begin
            res[res_n[1:0]] = mk_res(held_char_nxt, held_kind_nxt, held_first_nxt, 1'b0,
                                     1'b0, line_cur, tstart_nxt);
            res_n = res_n + 1'b1;
          end
          held_valid_nxt = 1'b1;
          held_char_nxt  = c;
          held_kind_nxt  = sct_pkg::KIND_STR;
          held_first_nxt = f;
        end
      end else if (in_word_nxt && !is_space(c) && !is_op(c) &&
                   (c != cx(sct_pkg::CH_HASH))) begin
        if (held_valid_nxt) begin
          res[res_n[1:0]] = mk_res(held_char_nxt, held_kind_nxt, held_first_nxt, 1'b0,
                                   1'b0, line_cur, tstart_nxt);
          res_n = res_n + 1'b1;
        end
        held_valid_nxt = 1'b1;
        held_char_nxt  = c;
        held_kind_nxt  = sct_pkg::KIND_WORD;
        held_first_nxt = 1'b0;
      end else begin
        // token boundary
        if (held_valid_nxt) begin
          res[res_n[1:0]] = mk_res(held_char_nxt, held_kind_nxt, held_first_nxt, 1'b1,
                                   1'b0, line_cur, tstart_nxt);
          res_n = res_n + 1'b1;
          held_valid_nxt = 1'b0;
        end
        in_word_nxt = 1'b0;
        if (is_space(c)) begin
          if ((c == cx(sct_pkg::CH_LF)) && (line_nxt != LINE_MAX)) begin
            line_nxt = line_nxt + 1'b1;
          end
        end else if (c == cx(sct_pkg::CH_HASH)) begin
          in_comment_nxt = 1'b1;
        end else if (c == cx(sct_pkg::CH_SLASH)) begin
          slash_pending_nxt = 1'b1;
          tstart_nxt        = pos_cur;
        end else if (is_op(c)) begin
          tstart_nxt     = pos_cur;
          held_valid_nxt = 1'b1;
          held_char_nxt  = c;
          held_kind_nxt  = sct_pkg::KIND_OP;
          held_first_nxt = 1'b1;
        end else if (c == cx(sct_pkg::CH_DQUOTE)) begin
          in_string_nxt = 1'b1;
          tstart_nxt    = pos_cur;
        end else begin
          in_word_nxt    = 1'b1;
          tstart_nxt     = pos_cur;
          held_valid_nxt = 1'b1;
          held_char_nxt  = c;
          held_kind_nxt  = sct_pkg::KIND_WORD;
          held_first_nxt = 1'b1;
        end
      end
    end

    // end of script
    if (ieod_r) begin
      if (slash_pending_nxt) begin
        res[res_n[1:0]] = mk_res(cx(sct_pkg::CH_SLASH), sct_pkg::KIND_OP, 1'b1, 1'b1, 1'b0,
                                 line_cur, tstart_nxt);
        res_n = res_n + 1'b1;
      end else if (quote_pending_nxt) begin
        if (held_valid_nxt) begin
          res[res_n[1:0]] = mk_res(held_char_nxt, held_kind_nxt, held_first_nxt, 1'b1,
                                   1'b0, line_cur,
                                   (pos_cur != POS_MAX) ? pos_cur + 1'b1 : POS_MAX);
        end else begin
          res[res_n[1:0]] = mk_res('0, sct_pkg::KIND_STR, 1'b1, 1'b1, 1'b1, line_cur,
                                   (pos_cur != POS_MAX) ? pos_cur + 1'b1 : POS_MAX);
        end
        res_n = res_n + 1'b1;
      end else if (in_string_nxt) begin
        had = held_valid_nxt;
        if (held_valid_nxt) begin
          res[res_n[1:0]] = mk_res(held_char_nxt, held_kind_nxt, held_first_nxt, 1'b0,
                                   1'b0, line_cur, tstart_nxt);
          res_n = res_n + 1'b1;
        end
        res[res_n[1:0]] = mk_res('0, sct_pkg::KIND_ERR, !had, 1'b1, 1'b0, line_cur,
                                 tstart_nxt);
        res_n = res_n + 1'b1;
      end else if (held_valid_nxt) begin
        res[res_n[1:0]] = mk_res(held_char_nxt, held_kind_nxt, held_first_nxt, 1'b1, 1'b0,
                                 line_cur, tstart_nxt);
        res_n = res_n + 1'b1;
      end
      held_valid_nxt = 1'b0;
      halted_nxt     = 1'b1;
    end

    if (pos_nxt != POS_MAX) pos_nxt = pos_nxt + 1'b1;
    if (res_n != '0) res[2'(res_n - 1'b1)].run_last = 1'b1;
  end

  // queue update: shift out the head, append this character's results behind
  always_comb begin
    for (int i = 0; i < sct_pkg::QDEPTH; i++) begin
      if (pop && (i < sct_pkg::QDEPTH - 1)) q_nxt[i] = q_r[i + 1];
      else q_nxt[i] = q_r[i];
      for (int k = 0; k < sct_pkg::MAX_RES; k++) begin
        if (proc && (RN_BITS'(k) < res_n) &&
            (CNT_BITS'(i) == cnt_after_pop + CNT_BITS'(k))) begin
          q_nxt[i] = res[k];
        end
      end
    end
    cnt_nxt = cnt_after_pop + (proc ? CNT_BITS'(res_n) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivalid_r        <= 1'b0;
      cnt_r           <= '0;
      in_comment_r    <= 1'b0;
      in_string_r     <= 1'b0;
      quote_pending_r <= 1'b0;
      slash_pending_r <= 1'b0;
      in_word_r       <= 1'b0;
      held_valid_r    <= 1'b0;
      held_char_r     <= '0;
      held_kind_r     <= sct_pkg::KIND_OP;
      held_first_r    <= 1'b0;
      line_r          <= '0;
      pos_r           <= '0;
      tstart_r        <= '0;
      halted_r        <= 1'b0;
    end else begin
      ivalid_r <= ivalid_nxt;
      cnt_r    <= cnt_nxt;
      if (proc) begin
        in_comment_r    <= in_comment_nxt;
        in_string_r     <= in_string_nxt;
        quote_pending_r <= quote_pending_nxt;
        slash_pending_r <= slash_pending_nxt;
        in_word_r       <= in_word_nxt;
        held_valid_r    <= held_valid_nxt;
        held_char_r     <= held_char_nxt;
        held_kind_r     <= held_kind_nxt;
        held_first_r    <= held_first_nxt;
        line_r          <= line_nxt;
        pos_r           <= pos_nxt;
        tstart_r        <= tstart_nxt;
        halted_r        <= halted_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ich_r  <= in_ch;
      ieod_r <= in_end_of_data;
    end
    for (int i = 0; i < sct_pkg::QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  assign out_tok_char     = q_r[0].tok_char;
  assign out_kind         = q_r[0].kind;
  assign out_token_first  = q_r[0].token_first;
  assign out_token_last   = q_r[0].token_last;
  assign out_empty_string = q_r[0].empty_string;
  assign out_line         = q_r[0].line;
  assign out_offset       = q_r[0].offset;
  assign out_run_last     = q_r[0].run_last;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_BITS'(sct_pkg::QDEPTH))
    else $error("result queue overflow");

  a_res_shown: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && (res_n != '0)) |=> out_valid)
    else $error("results of a character not queued");

  a_empty_str: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_empty_string) |->
      ((out_kind == sct_pkg::KIND_STR) && out_token_first && out_token_last))
    else $error("empty string result malformed");

  a_eod_halt: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && ieod_r) |=> (halted_r && !held_valid_r))
    else $error("end of script did not flush the held character");

endmodule

// ===== tb/tb_script_char_tokenizer.sv =====
`timescale 1ns / 1ps

module tb_script_char_tokenizer;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int TAIL_CYCLES = 32;
  localparam int RANDOM_CHARS = 280;
  localparam int MAX_REPORTS = 40;
  localparam logic [15:0] LINE_TOP = 16'hffff;
  localparam logic [23:0] POS_TOP = 24'hffffff;

  typedef struct packed {
    logic [7:0]  ch;
    logic [1:0]  kind;
    logic        first;
    logic        last;
    logic        empty;
    logic [15:0] line;
    logic [23:0] offset;
    logic        run_last;
  } tok_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_ch = 8'h00;
  logic        in_end_of_data = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_tok_char;
  logic [1:0]  out_kind;
  logic        out_token_first;
  logic        out_token_last;
  logic        out_empty_string;
  logic [15:0] out_line;
  logic [23:0] out_offset;
  logic        out_run_last;

  // lexer state mirrored on the testbench side
  logic           cmt_open, str_open, quote_seen, slash_seen, word_open;
  logic           hold_v, hold_first, script_done;
  logic [7:0]     hold_ch;
  sct_pkg::kind_t hold_kind;
  logic [15:0]    line_no;
  logic [23:0]    char_pos, tok_start;

  tok_res_t    tokens_due[$];
  tok_res_t    want, got;
  logic [7:0]  script_buf[$];

  int burst_left = 0;
  int chars_sent = 0;
  int scripts_sent = 0;
  int results_seen = 0;
  int err_cnt = 0;
  int cycle_cnt = 0;
  int rx_tick = 0;
  int rx_mode = 0;

  script_char_tokenizer DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_ch            (in_ch),
    .in_end_of_data   (in_end_of_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_tok_char     (out_tok_char),
    .out_kind         (out_kind),
    .out_token_first  (out_token_first),
    .out_token_last   (out_token_last),
    .out_empty_string (out_empty_string),
    .out_line         (out_line),
    .out_offset       (out_offset),
    .out_run_last     (out_run_last)
  );

  initial forever #2 clk = ~clk;

  function automatic logic is_blank(input logic [7:0] c);
    return c == sct_pkg::CH_SPACE || c == sct_pkg::CH_TAB || c == sct_pkg::CH_CR ||
           c == sct_pkg::CH_LF || c == sct_pkg::CH_NUL;
  endfunction

  function automatic logic is_op_char(input logic [7:0] c);
    return c == sct_pkg::CH_COMMA || c == sct_pkg::CH_EQ || c == sct_pkg::CH_LPAR ||
           c == sct_pkg::CH_RPAR || c == sct_pkg::CH_SEMI || c == sct_pkg::CH_LBRACE ||
           c == sct_pkg::CH_RBRACE || c == sct_pkg::CH_LT || c == sct_pkg::CH_PLUS ||
           c == sct_pkg::CH_MINUS || c == sct_pkg::CH_STAR || c == sct_pkg::CH_SLASH ||
           c == sct_pkg::CH_GT;
  endfunction

  function automatic void clear_lexer();
    cmt_open = 1'b0;
    str_open = 1'b0;
    quote_seen = 1'b0;
    slash_seen = 1'b0;
    word_open = 1'b0;
    hold_v = 1'b0;
    hold_first = 1'b0;
    script_done = 1'b0;
    hold_ch = 8'h00;
    hold_kind = sct_pkg::KIND_OP;
    line_no = 16'd0;
    char_pos = 24'd0;
    tok_start = 24'd0;
  endfunction

  function automatic void push_token(input logic [7:0] c, input sct_pkg::kind_t k,
                                     input logic first, input logic last,
                                     input logic empty, input logic [23:0] off);
    tok_res_t r;
    r.ch = c;
    r.kind = k;
    r.first = first;
    r.last = last;
    r.empty = empty;
    r.line = line_no;
    r.offset = off;
    r.run_last = 1'b0;
    tokens_due.insert(tokens_due.size(), r);
  endfunction

  function automatic void add_byte(input logic [7:0] c);
    script_buf.insert(script_buf.size(), c);
  endfunction

  function automatic void bump_line();
    if (line_no != LINE_TOP) line_no = line_no + 16'd1;
  endfunction

  function automatic void flush_held(input logic [23:0] off);
    if (hold_v) begin
      push_token(hold_ch, hold_kind, hold_first, 1'b1, 1'b0, off);
      hold_v = 1'b0;
    end
  endfunction

  function automatic void hold_token(input logic [7:0] c, input sct_pkg::kind_t k,
                                     input logic first);
    if (hold_v) push_token(hold_ch, hold_kind, hold_first, 1'b0, 1'b0, tok_start);
    hold_v = 1'b1;
    hold_ch = c;
    hold_kind = k;
    hold_first = first;
  endfunction

  function automatic void close_str(input logic [23:0] off);
    if (hold_v) flush_held(off);
    else push_token(8'h00, sct_pkg::KIND_STR, 1'b1, 1'b1, 1'b1, off);
    str_open = 1'b0;
  endfunction

  function automatic void take_char(input logic [7:0] c, input logic [23:0] pos);
    if (cmt_open) begin
      if (c == sct_pkg::CH_LF) begin
        cmt_open = 1'b0;
        bump_line();
      end
      return;
    end
    if (str_open) begin
      if (c == sct_pkg::CH_DQUOTE) quote_seen = 1'b1;
      else hold_token(c, sct_pkg::KIND_STR, !hold_v);
      return;
    end
    if (word_open && !is_blank(c) && !is_op_char(c) && c != sct_pkg::CH_HASH) begin
      hold_token(c, sct_pkg::KIND_WORD, 1'b0);
      return;
    end
    flush_held(tok_start);
    word_open = 1'b0;
    if (is_blank(c)) begin
      if (c == sct_pkg::CH_LF) bump_line();
    end else if (c == sct_pkg::CH_HASH) begin
      cmt_open = 1'b1;
    end else if (c == sct_pkg::CH_SLASH) begin
      slash_seen = 1'b1;
      tok_start = pos;
    end else if (is_op_char(c)) begin
      tok_start = pos;
      hold_token(c, sct_pkg::KIND_OP, 1'b1);
    end else if (c == sct_pkg::CH_DQUOTE) begin
      str_open = 1'b1;
      tok_start = pos;
    end else begin
      word_open = 1'b1;
      tok_start = pos;
      hold_token(c, sct_pkg::KIND_WORD, 1'b1);
    end
  endfunction

  // one accepted character: queue the token results it releases
  function automatic void lex_char(input logic [7:0] c, input logic eod);
    logic [23:0] pos;
    int          base;
    logic        had;
    tok_res_t    r;
    if (script_done) clear_lexer();
    base = tokens_due.size();
    pos = char_pos;
    if (slash_seen) begin
      slash_seen = 1'b0;
      if (c == sct_pkg::CH_SLASH) begin
        cmt_open = 1'b1;
      end else begin
        hold_token(sct_pkg::CH_SLASH, sct_pkg::KIND_OP, 1'b1);
        take_char(c, pos);
      end
    end else if (quote_seen) begin
      quote_seen = 1'b0;
      if (c == sct_pkg::CH_DQUOTE) begin
        hold_token(sct_pkg::CH_DQUOTE, sct_pkg::KIND_STR, !hold_v);
      end else begin
        close_str(pos);
        take_char(c, pos);
      end
    end else begin
      take_char(c, pos);
    end
    if (eod) begin
      if (slash_seen) begin
        push_token(sct_pkg::CH_SLASH, sct_pkg::KIND_OP, 1'b1, 1'b1, 1'b0, tok_start);
      end else if (quote_seen) begin
        close_str(pos != POS_TOP ? pos + 24'd1 : POS_TOP);
      end else if (str_open) begin
        had = hold_v;
        if (hold_v) begin
          push_token(hold_ch, hold_kind, hold_first, 1'b0, 1'b0, tok_start);
          hold_v = 1'b0;
        end
        push_token(8'h00, sct_pkg::KIND_ERR, !had, 1'b1, 1'b0, tok_start);
      end else begin
        flush_held(tok_start);
      end
      script_done = 1'b1;
    end
    if (char_pos != POS_TOP) char_pos = char_pos + 24'd1;
    if (tokens_due.size() > base) begin
      r = tokens_due[tokens_due.size() - 1];
      r.run_last = 1'b1;
      tokens_due[tokens_due.size() - 1] = r;
    end
  endfunction

  task automatic send_char(input logic [7:0] c, input logic eod);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_ch <= c;
    in_end_of_data <= eod;
    do @(posedge clk); while (!in_ready);
    lex_char(c, eod);
    chars_sent++;
    if (eod) scripts_sent++;
  endtask

  task automatic send_text(input string s, input logic eod_last);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], eod_last && i == s.len() - 1);
  endtask

  function automatic logic [7:0] word_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (is_blank(c) || is_op_char(c) || c == sct_pkg::CH_HASH ||
           c == sct_pkg::CH_DQUOTE);
    return c;
  endfunction

  function automatic logic [7:0] op_byte();
    case ($urandom_range(0, 12))
      0: return sct_pkg::CH_COMMA;
      1: return sct_pkg::CH_EQ;
      2: return sct_pkg::CH_LPAR;
      3: return sct_pkg::CH_RPAR;
      4: return sct_pkg::CH_SEMI;
      5: return sct_pkg::CH_LBRACE;
      6: return sct_pkg::CH_RBRACE;
      7: return sct_pkg::CH_LT;
      8: return sct_pkg::CH_PLUS;
      9: return sct_pkg::CH_MINUS;
      10: return sct_pkg::CH_STAR;
      11: return sct_pkg::CH_SLASH;
      default: return sct_pkg::CH_GT;
    endcase
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 4))
      0: return sct_pkg::CH_SPACE;
      1: return sct_pkg::CH_TAB;
      2: return sct_pkg::CH_CR;
      3: return sct_pkg::CH_LF;
      default: return sct_pkg::CH_NUL;
    endcase
  endfunction

  task automatic build_script();
    logic [7:0] c;
    script_buf.delete();
    repeat ($urandom_range(1, 12)) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          add_byte(word_byte());
          repeat ($urandom_range(0, 5))
            add_byte($urandom_range(0, 7) == 0 ? sct_pkg::CH_DQUOTE : word_byte());
        end
        2, 3: add_byte(op_byte());
        4, 5: begin
          add_byte(sct_pkg::CH_DQUOTE);
          repeat ($urandom_range(0, 5)) begin
            if ($urandom_range(0, 4) == 0) begin
              add_byte(sct_pkg::CH_DQUOTE);
              add_byte(sct_pkg::CH_DQUOTE);
            end else begin
              c = 8'($urandom_range(0, 255));
              add_byte(c == sct_pkg::CH_DQUOTE ? sct_pkg::CH_SPACE : c);
            end
          end
          add_byte(sct_pkg::CH_DQUOTE);
        end
        6: begin
          if ($urandom_range(0, 1) == 0) begin
            add_byte(sct_pkg::CH_HASH);
          end else begin
            add_byte(sct_pkg::CH_SLASH);
            add_byte(sct_pkg::CH_SLASH);
          end
          repeat ($urandom_range(0, 4)) begin
            c = 8'($urandom_range(0, 255));
            add_byte(c == sct_pkg::CH_LF ? sct_pkg::CH_SEMI : c);
          end
          if ($urandom_range(0, 3) != 0) add_byte(sct_pkg::CH_LF);
        end
        7, 8: add_byte(blank_byte());
        default: add_byte(8'($urandom_range(0, 255)));
      endcase
    end
    // broken endings: open string or a dangling slash
    case ($urandom_range(0, 7))
      0: begin
        add_byte(sct_pkg::CH_DQUOTE);
        repeat ($urandom_range(0, 3)) add_byte(word_byte());
      end
      1: add_byte(sct_pkg::CH_SLASH);
      default: ;
    endcase
  endtask

  task automatic test_operators_and_words();
    send_text("=(){};,<+-*/>", 1'b0);
    send_char(8'h01, 1'b0);
    send_char(sct_pkg::CH_DQUOTE, 1'b0);
    send_char(8'hff, 1'b0);
    send_char(sct_pkg::CH_HASH, 1'b0);
    send_char(sct_pkg::CH_LF, 1'b0);
    send_char(sct_pkg::CH_NUL, 1'b0);
  endtask

  task automatic test_strings();
    send_text("\"\" ", 1'b0);
    send_text("\"\"\"x\"", 1'b1);
  endtask

  task automatic test_comments_and_slash();
    send_text("a//b\n", 1'b0);
    send_text("/", 1'b1);
  endtask

  task automatic test_unterminated();
    send_text("\"ab", 1'b1);
    send_text("\"", 1'b1);
  endtask

  task automatic test_random_scripts();
    int start;
    logic eod_at_end;
    start = chars_sent;
    while (chars_sent - start < RANDOM_CHARS) begin
      build_script();
      eod_at_end = $urandom_range(0, 4) != 0;
      for (int i = 0; i < script_buf.size(); i++)
        send_char(script_buf[i], eod_at_end && i == script_buf.size() - 1);
    end
  endtask

  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 48 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 2) != 0;
      2: out_ready <= (rx_tick % 5) > 1;
      default: out_ready <= (rx_tick % 9) == 0;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got = {out_tok_char, out_kind, out_token_first, out_token_last, out_empty_string,
             out_line, out_offset, out_run_last};
      if (tokens_due.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, got ch=%h kind=%0d", $time,
                   got.ch, got.kind);
      end else begin
        want = tokens_due[0];
        tokens_due.delete(0);
        results_seen++;
        if (got !== want) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS) begin
            $display("%0t: expected ch=%h kind=%0d first=%b last=%b empty=%b line=%0d",
                     $time, want.ch, want.kind, want.first, want.last, want.empty, want.line);
            $display("    offset=%0d run_last=%b", want.offset, want.run_last);
            $display("%0t: actual   ch=%h kind=%0d first=%b last=%b empty=%b line=%0d",
                     $time, got.ch, got.kind, got.first, got.last, got.empty, got.line);
            $display("    offset=%0d run_last=%b", got.offset, got.run_last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, tokens_due.size());
      $display("FAIL script_char_tokenizer");
      $finish;
    end
  end

  initial begin
    clear_lexer();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_operators_and_words();
    test_strings();
    test_comments_and_slash();
    test_unterminated();
    test_random_scripts();
    in_valid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("lexed %0d characters over %0d scripts: operators, words, strings, comments,",
             chars_sent, scripts_sent);
    $display("open strings, end-of-script flushes; %0d token results checked, %0d errors",
             results_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("PASS script_char_tokenizer");
    end else begin
      $display("FAIL script_char_tokenizer");
    end
    $finish;
  end

endmodule
